@@ sv/tbd_pkg.sv @@
// Package with shared types, codes and helpers for the typed byte decoder.
package tbd_pkg;

  typedef enum logic [2:0] {
    OP_U8  = 3'd0,
    OP_I8  = 3'd1,
    OP_U16 = 3'd2,
    OP_I16 = 3'd3,
    OP_U32 = 3'd4,
    OP_I32 = 3'd5,
    OP_F32 = 3'd6,
    OP_F64 = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_F32,
    KIND_F64
  } kind_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic [32:0] mag;
    logic [63:0] word;
    logic [3:0]  byte_count;
  } item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // Position of the most significant set bit of a 33-bit value.
  function automatic logic [5:0] msb_pos33(input logic [32:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

@@ sv/tbd_front.sv @@
// Front part: gathers the field bytes and classifies the item.
module tbd_front import tbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_order,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [63:0] raw_bytes,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t       item;
  logic [63:0] w;
  logic [3:0]  n;
  item_t       slot [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic        push, pop;

  always_comb begin
    w = '0;
    case (opcode_t'(opcode))
      OP_U8, OP_I8: begin
        n = 4'd1;
        w[7:0] = raw_bytes[7:0];
      end
      OP_U16, OP_I16: begin
        n = 4'd2;
        w[15:0] = byte_order ? {raw_bytes[7:0], raw_bytes[15:8]} : raw_bytes[15:0];
      end
      OP_U32, OP_I32, OP_F32: begin
        n = 4'd4;
        w[31:0] = byte_order ? {raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16],
                                raw_bytes[31:24]} : raw_bytes[31:0];
      end
      default: begin
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
          w[8*i +: 8] = byte_order ? raw_bytes[8*(7-i) +: 8] : raw_bytes[8*i +: 8];
        end
      end
    endcase
    item.word       = w;
    item.byte_count = n;
    item.neg        = 1'b0;
    item.mag        = {1'b0, w[31:0]};
    item.kind       = KIND_INT;
    case (opcode_t'(opcode))
      OP_I8: begin
        item.neg = w[7];
        item.mag = w[7] ? 33'(9'h100 - {1'b0, w[7:0]}) : {25'd0, w[7:0]};
      end
      OP_I16: begin
        item.neg = w[15];
        item.mag = w[15] ? 33'(17'h10000 - {1'b0, w[15:0]}) : {17'd0, w[15:0]};
      end
      OP_I32: begin
        item.neg = w[31];
        item.mag = w[31] ? 33'(33'h100000000 - {1'b0, w[31:0]}) : {1'b0, w[31:0]};
      end
      OP_F32:  item.kind = KIND_F32;
      OP_F64:  item.kind = KIND_F64;
      default: item.kind = KIND_INT;
    endcase
  end

  assign in_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> count == (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("bad ready");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule

@@ sv/tbd_back.sv @@
// Back part: converts a classified item into a double and holds the result.
module tbd_back import tbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_bits,
  output logic [3:0]  byte_count
);

  logic [63:0] v;
  logic [5:0]  p;
  logic [32:0] src;
  logic [84:0] sh;
  logic [7:0]  ex;
  logic [22:0] fr;

  always_comb begin
    ex  = q_item.word[30:23];
    fr  = q_item.word[22:0];
    src = (q_item.kind == KIND_F32) ? {10'd0, fr} : q_item.mag;
    p   = msb_pos33(src);
    sh  = {52'd0, src} << (6'd52 - p);
    v   = '0;
    case (q_item.kind)
      KIND_INT: begin
        if (src != '0) v = {q_item.neg, 11'(11'd1023 + 11'(p)), sh[51:0]};
      end
      KIND_F32: begin
        v[63] = q_item.word[31];
        if (ex == 8'hFF) v[62:0] = {11'h7FF, fr, 29'd0};
        else if (ex == 8'd0) begin
          if (fr != '0) v[62:0] = {11'(11'd874 + 11'(p)), sh[51:0]};
        end else v[62:0] = {11'(11'(ex) + 11'd896), fr, 29'd0};
      end
      default: v = q_item.word;
    endcase
  end

  assign q_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      value_bits <= v;
      byte_count <= q_item.byte_count;
    end
    if (rst) out_valid <= 1'b0;
    else if (q_ready) out_valid <= q_valid;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(value_bits))
    else $error("result lost");
  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count == 4'd1 || byte_count == 4'd2 ||
                   byte_count == 4'd4 || byte_count == 4'd8))
    else $error("bad byte count");
  a_load: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> out_valid) else $error("result not shown");

endmodule

@@ sv/typed_bytes_to_double_top.sv @@
// Top level of the typed byte to double decoder.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  config   | cfg_valid / cfg_ready | cfg_data (byte_order, bit 0)
//  input    | in_valid / in_ready   | opcode, raw_bytes
//  output   | out_valid / out_ready | value_bits, byte_count
//
// One transaction is accepted per cycle while in_ready is high. An input
// transaction is written into the front queue, then moves into the output
// register when the back part is ready, and leaves as an output transaction.
// The path runs through the front queue and the result register.
// Reset clears the queue, the result valid flag and byte_order.
// A stalled output fills the queue, after which in_ready drops.
// Configuration writes are always accepted.
module typed_bytes_to_double_top import tbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [63:0] raw_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_bits,
  output logic [3:0]  byte_count
);

  logic  byte_order;
  logic  q_valid, q_ready;
  item_t q_item;

  // The single configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) byte_order <= 1'b0;
    else if (cfg_valid) byte_order <= cfg_data;
  end

  // The front gathers and classifies, the back converts.
  tbd_front u_front (
    .clk, .rst, .byte_order, .in_valid, .in_ready, .opcode, .raw_bytes,
    .q_valid, .q_ready, .q_item
  );

  tbd_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .value_bits, .byte_count
  );

endmodule
